// ----- rtl/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper: word formats,
// controller kinds, register indexes and save RAM geometry.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam int RAM_BYTES     = 131072;
   localparam int RAM_ADDR_W    = $clog2(RAM_BYTES);
   localparam int ROM_ADDR_BITS = 23;
   localparam int RAM_SIZE_W    = 18;
   localparam int ROM_LIM_W     = 25;

   localparam logic [ROM_LIM_W-1:0] ROM_CAP    = ROM_LIM_W'(1) << ROM_ADDR_BITS;
   localparam logic [23:0]          HEADER_END = 24'h000150;

   localparam logic [1:0] CSR_CART_TYPE = 2'd0;
   localparam logic [1:0] CSR_RAM_SIZE  = 2'd1;
   localparam logic [1:0] CSR_ROM_SIZE  = 2'd2;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_MBC1,
      KIND_MBC3,
      KIND_MBC5
   } ctrl_kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RAM_READ
   } state_type;

   typedef struct packed {
      logic        func;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        rom_fetch;
      logic [22:0] rom_address;
   } rsp_word_type;

   function automatic logic [RAM_SIZE_W-1:0] ram_bytes_for_code(input logic [7:0] code);
      logic [RAM_SIZE_W-1:0] s;
      case (code)
         8'd1:    s = RAM_SIZE_W'(2048);
         8'd2:    s = RAM_SIZE_W'(8192);
         8'd3:    s = RAM_SIZE_W'(32768);
         8'd4:    s = RAM_SIZE_W'(131072);
         8'd5:    s = RAM_SIZE_W'(65536);
         default: s = '0;
      endcase
      if (s > RAM_SIZE_W'(RAM_BYTES)) s = RAM_SIZE_W'(RAM_BYTES);
      return s;
   endfunction

endpackage

// ----- rtl/cartridge_bank_mapper_core.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_core
// Memory bank controller of a handheld game cartridge: bank registers,
// ROM address translation and a banked save RAM in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_ready  | req_word  (func, address, write_data)
//  rsp_    | out       | rsp_valid/rsp_ready  | rsp_word  (read_data, rom_fetch, rom_address)
//  csr_    | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
//  Writes, ROM reads, unmapped reads and gated RAM reads are answered from
//  the output register: one word per cycle while that register can drain.
//  Mapped save RAM reads pass the registered RAM read port, then the output register; no new word is taken meanwhile.
//  After reset the save RAM is swept to zero, one byte a cycle, with
//  req_ready low; csr writes are taken throughout.
//  A result waits in the output register; a new word is taken in the cycle
//  that register drains.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cbm_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cbm_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_wdata
);

   localparam int AW = cbm_pkg::RAM_ADDR_W;
   localparam int LW = cbm_pkg::ROM_LIM_W;

   cbm_pkg::state_type state_ff, state_in;

   logic [7:0]  cart_type_ff;
   logic [7:0]  ram_size_code_ff;
   logic [23:0] rom_size_ff;

   logic [7:0] bank_low_ff, bank_low_in;
   logic [1:0] bank_high_ff, bank_high_in;
   logic [8:0] active_rom_bank_ff, active_rom_bank_in;
   logic [3:0] active_ram_bank_ff, active_ram_bank_in;
   logic       ram_enable_ff, ram_enable_in;
   logic       bank_mode_ff, bank_mode_in;

   logic [AW-1:0] clr_ptr_ff;
   logic          clr_last;

   logic                  rsp_valid_ff, rsp_valid_in;
   cbm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [7:0]    save_ram [cbm_pkg::RAM_BYTES];
   logic [7:0]    mem_rd_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0]    mem_wd;

   cbm_pkg::ctrl_kind_type kind;
   logic                   short_image;
   logic [cbm_pkg::RAM_SIZE_W-1:0] ram_sz;
   logic [LW-1:0]          rom_lim;

   logic        accept;
   logic        is_write;
   logic [15:0] addr;
   logic [7:0]  wv;
   logic        rom_lo, rom_hi, ram_win;
   logic [3:0]  sel_ram_bank;
   logic [16:0] ram_off;
   logic        ram_ok;
   logic [22:0] rom_plain, rom_mbc1_lo, rom_a_lo, rom_a_hi, rom_a;
   logic        rom_ok;
   logic [4:0]  mbc1_low;
   logic [6:0]  mbc3_bank;
   cbm_pkg::rsp_word_type now_word;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign is_write = req_word.func;
   assign addr     = req_word.address;
   assign wv       = req_word.write_data;
   assign accept   = req_valid & req_ready;

   // controller kind, sizes and limits
   always_comb begin
      short_image = rom_size_ff < cbm_pkg::HEADER_END;
      kind        = cbm_pkg::KIND_NONE;
      if (!short_image) begin
         if (cart_type_ff inside {[8'h01:8'h03]}) begin
            kind = cbm_pkg::KIND_MBC1;
         end else if (cart_type_ff inside {[8'h0F:8'h13]}) begin
            kind = cbm_pkg::KIND_MBC3;
         end else if (cart_type_ff inside {[8'h19:8'h1E]}) begin
            kind = cbm_pkg::KIND_MBC5;
         end
      end
      ram_sz  = short_image ? '0 : cbm_pkg::ram_bytes_for_code(ram_size_code_ff);
      rom_lim = ({1'b0, rom_size_ff} < cbm_pkg::ROM_CAP) ? {1'b0, rom_size_ff}
                                                          : cbm_pkg::ROM_CAP;
   end

   // address translation
   always_comb begin
      rom_lo  = addr[15:14] == 2'b00;
      rom_hi  = addr[15:14] == 2'b01;
      ram_win = addr[15:13] == 3'b101;

      sel_ram_bank = ((kind == cbm_pkg::KIND_MBC1 && bank_mode_ff) ||
                      kind == cbm_pkg::KIND_MBC3 || kind == cbm_pkg::KIND_MBC5)
                     ? active_ram_bank_ff : 4'd0;
      ram_off  = {sel_ram_bank, addr[12:0]};
      ram_ok   = ram_enable_ff && (ram_sz != '0) && ({1'b0, ram_off} < ram_sz);

      rom_plain   = {9'd0, addr[13:0]};
      rom_mbc1_lo = {2'd0, bank_high_ff, 5'd0, addr[13:0]};
      rom_a_lo    = (kind == cbm_pkg::KIND_MBC1 && bank_mode_ff &&
                     {2'b0, rom_mbc1_lo} < rom_lim) ? rom_mbc1_lo : rom_plain;
      rom_a_hi    = {active_rom_bank_ff, addr[13:0]};
      rom_a       = rom_lo ? rom_a_lo : rom_a_hi;
      rom_ok      = {2'b0, rom_a} < rom_lim;

      now_word = '0;
      if (!is_write) begin
         if (rom_lo || rom_hi) begin
            now_word.rom_fetch   = rom_ok;
            now_word.rom_address = rom_ok ? rom_a : '0;
         end else begin
            now_word.read_data = 8'hFF;
         end
      end
   end

   // bank register updates
   always_comb begin
      bank_low_in        = bank_low_ff;
      bank_high_in       = bank_high_ff;
      active_rom_bank_in = active_rom_bank_ff;
      active_ram_bank_in = active_ram_bank_ff;
      ram_enable_in      = ram_enable_ff;
      bank_mode_in       = bank_mode_ff;
      mbc1_low           = (wv[4:0] == 5'd0) ? 5'd1 : wv[4:0];
      mbc3_bank          = (wv[6:0] == 7'd0) ? 7'd1 : wv[6:0];
      if (accept && is_write) begin
         case (addr[15:13])
            3'b000: begin
               if (kind != cbm_pkg::KIND_NONE) ram_enable_in = wv[3:0] == 4'hA;
            end
            3'b001: begin
               case (kind)
                  cbm_pkg::KIND_MBC1: begin
                     bank_low_in        = {3'd0, mbc1_low};
                     active_rom_bank_in = {2'd0, bank_high_ff, mbc1_low};
                  end
                  cbm_pkg::KIND_MBC3: begin
                     active_rom_bank_in = {2'd0, mbc3_bank};
                  end
                  cbm_pkg::KIND_MBC5: begin
                     if (!addr[12]) begin
                        bank_low_in        = wv;
                        active_rom_bank_in = {bank_high_ff[0], wv};
                     end else begin
                        bank_high_in       = {1'b0, wv[0]};
                        active_rom_bank_in = {wv[0], bank_low_ff};
                     end
                  end
                  default: ;
               endcase
            end
            3'b010: begin
               case (kind)
                  cbm_pkg::KIND_MBC1: begin
                     bank_high_in       = wv[1:0];
                     active_ram_bank_in = {2'd0, wv[1:0]};
                     active_rom_bank_in = {2'd0, wv[1:0], bank_low_ff[4:0]};
                  end
                  cbm_pkg::KIND_MBC3, cbm_pkg::KIND_MBC5: begin
                     active_ram_bank_in = wv[3:0];
                  end
                  default: ;
               endcase
            end
            3'b011: begin
               if (kind == cbm_pkg::KIND_MBC1) bank_mode_in = wv[0];
            end
            default: ;
         endcase
      end
   end

   // sequencer: next state, handshake, RAM port and output register
   always_comb begin
      clr_last     = clr_ptr_ff == AW'(cbm_pkg::RAM_BYTES - 1);
      state_in     = state_ff;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = ram_off[AW-1:0];
      mem_wd       = wv;
      mem_re       = 1'b0;
      mem_ra       = ram_off[AW-1:0];
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         cbm_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ptr_ff;
            mem_wd = 8'h00;
            if (clr_last) state_in = cbm_pkg::ST_IDLE;
         end
         cbm_pkg::ST_IDLE: begin
            req_ready = ~rsp_valid_ff | rsp_ready;
            if (accept) begin
               if (ram_win && ram_ok && !is_write) begin
                  mem_re   = 1'b1;
                  state_in = cbm_pkg::ST_RAM_READ;
               end else begin
                  mem_we       = is_write && ram_win && ram_ok;
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = now_word;
               end
            end
         end
         cbm_pkg::ST_RAM_READ: begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = '{read_data: mem_rd_ff, rom_fetch: 1'b0, rom_address: '0};
            state_in     = cbm_pkg::ST_IDLE;
         end
         default: begin
            state_in = cbm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff         <= '0;
         rsp_valid_ff       <= 1'b0;
         bank_low_ff        <= 8'd1;
         bank_high_ff       <= 2'd0;
         active_rom_bank_ff <= 9'd1;
         active_ram_bank_ff <= 4'd0;
         ram_enable_ff      <= 1'b0;
         bank_mode_ff       <= 1'b0;
      end else begin
         if (state_ff == cbm_pkg::ST_CLEAR) clr_ptr_ff <= clr_ptr_ff + AW'(1);
         rsp_valid_ff       <= rsp_valid_in;
         bank_low_ff        <= bank_low_in;
         bank_high_ff       <= bank_high_in;
         active_rom_bank_ff <= active_rom_bank_in;
         active_ram_bank_ff <= active_ram_bank_in;
         ram_enable_ff      <= ram_enable_in;
         bank_mode_ff       <= bank_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_type_ff     <= '0;
         ram_size_code_ff <= '0;
         rom_size_ff      <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            cbm_pkg::CSR_CART_TYPE: cart_type_ff     <= csr_wdata[7:0];
            cbm_pkg::CSR_RAM_SIZE:  ram_size_code_ff <= csr_wdata[7:0];
            cbm_pkg::CSR_ROM_SIZE:  rom_size_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) save_ram[mem_wa] <= mem_wd;
      if (mem_re) mem_rd_ff <= save_ram[mem_ra];
   end

endmodule

// ----- rtl/cbm_checker.sv -----
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks of the cartridge bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module cbm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input cbm_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input cbm_pkg::rsp_word_type rsp_word
);

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("word accepted during save RAM sweep");

   a_write_zero_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_word.func) |=> (rsp_valid && rsp_word == '0))
      else $error("write access did not return an all-zero word");

   a_fetch_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.rom_fetch) |-> rsp_word.read_data == 8'h00)
      else $error("ROM fetch with nonzero read data");

   a_no_fetch_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.rom_fetch) |-> rsp_word.rom_address == '0)
      else $error("ROM address without ROM fetch");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled response word changed");

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// ----- sim/tb_cartridge_bank_mapper_core.sv -----
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_core
// Self-checking bench for the cartridge bank mapper. A short table of bus
// accesses and register writes walks the controller kinds, bank-zero
// mapping, the MBC1 low-window remap, ROM bounds and save RAM gating; then
// random segments, each with its own register setting and idling pattern,
// run mostly well-formed bank and RAM traffic. Every result word is checked
// field by field, against the fixed answer of a checked table row or else
// an in-bench mapper that tracks the bank state and a mirror of the save RAM.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic        FUNC_READ      = 1'b0;
   localparam logic        FUNC_WRITE     = 1'b1;
   localparam logic [1:0]  CSR_UNUSED     = 2'd3;
   localparam int unsigned ROM_BANK_BYTES = 32'h4000;
   localparam int unsigned RAM_BANK_BYTES = 32'h2000;
   localparam int unsigned RAM_BASE       = 32'hA000;
   localparam int unsigned ROM_CAP_BYTES  = 32'd1 << cbm_pkg::ROM_ADDR_BITS;
   localparam int unsigned CYCLE_LIMIT    = 1_000_000;
   localparam int unsigned SEGMENTS       = 8;
   localparam int unsigned SEGMENT_WORDS  = 190;

   typedef struct {
      logic                  is_reg;
      logic [1:0]            reg_index;
      logic [23:0]           reg_value;
      cbm_pkg::req_word_type word;
      logic                  typed;
      cbm_pkg::rsp_word_type want;
   } plan_row_type;

   typedef struct {
      logic                  typed;
      cbm_pkg::rsp_word_type want;
   } fixed_answer_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   cbm_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   cbm_pkg::rsp_word_type rsp_word;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [1:0]            csr_index;
   logic [23:0]           csr_wdata;

   // mapper state as the bench sees it
   logic [7:0]  cfg_cart_type;
   logic [7:0]  cfg_ram_code;
   logic [23:0] cfg_rom_bytes;
   logic [7:0]  bank_low;
   logic [1:0]  bank_high;
   logic [8:0]  rom_bank;
   logic [3:0]  cur_ram_bank;
   logic        ram_on;
   logic        bank_mode;
   logic [7:0]  save_ram_copy [cbm_pkg::RAM_BYTES];

   cbm_pkg::rsp_word_type pending_results [$];
   fixed_answer_type      fixed_answers [$];
   plan_row_type          directed_plan [$];

   int unsigned mismatch_count = 0;
   int unsigned bus_words      = 0;
   int unsigned reg_writes     = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;

   cartridge_bank_mapper_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic cbm_pkg::ctrl_kind_type decode_kind();
      if (cfg_rom_bytes < cbm_pkg::HEADER_END) return cbm_pkg::KIND_NONE;
      if (cfg_cart_type >= 8'h01 && cfg_cart_type <= 8'h03) return cbm_pkg::KIND_MBC1;
      if (cfg_cart_type >= 8'h0F && cfg_cart_type <= 8'h13) return cbm_pkg::KIND_MBC3;
      if (cfg_cart_type >= 8'h19 && cfg_cart_type <= 8'h1E) return cbm_pkg::KIND_MBC5;
      return cbm_pkg::KIND_NONE;
   endfunction

   function automatic int unsigned ram_span();
      int unsigned s;
      if (cfg_rom_bytes < cbm_pkg::HEADER_END) return 0;
      case (cfg_ram_code)
         8'd1:    s = 2048;
         8'd2:    s = 8192;
         8'd3:    s = 32768;
         8'd4:    s = 131072;
         8'd5:    s = 65536;
         default: s = 0;
      endcase
      if (s > cbm_pkg::RAM_BYTES) s = cbm_pkg::RAM_BYTES;
      return s;
   endfunction

   function automatic logic ram_slot(input cbm_pkg::ctrl_kind_type kind,
                                     input logic [15:0] addr,
                                     output int unsigned idx);
      int unsigned size;
      int unsigned bank;
      int unsigned offs;
      size = ram_span();
      bank = 0;
      idx  = 0;
      if (!ram_on || size == 0) return 1'b0;
      if ((kind == cbm_pkg::KIND_MBC1 && bank_mode) || kind == cbm_pkg::KIND_MBC3 ||
          kind == cbm_pkg::KIND_MBC5)
         bank = 32'(cur_ram_bank);
      offs = bank * RAM_BANK_BYTES + (32'(addr) - RAM_BASE);
      if (offs >= size) return 1'b0;
      idx = offs;
      return 1'b1;
   endfunction

   function automatic void apply_write(input cbm_pkg::ctrl_kind_type kind,
                                       input logic [15:0] addr, input logic [7:0] v);
      int unsigned idx;
      if (addr <= 16'h1FFF) begin
         if (kind != cbm_pkg::KIND_NONE) ram_on = (v[3:0] == 4'hA);
      end else if (addr <= 16'h3FFF) begin
         case (kind)
            cbm_pkg::KIND_MBC1: begin
               bank_low = {3'd0, v[4:0]};
               if (bank_low == 8'd0) bank_low = 8'd1;
               rom_bank = {2'b00, bank_high, bank_low[4:0]};
            end
            cbm_pkg::KIND_MBC3: begin
               rom_bank = {2'b00, v[6:0]};
               if (rom_bank == 9'd0) rom_bank = 9'd1;
            end
            cbm_pkg::KIND_MBC5: begin
               if (addr <= 16'h2FFF) bank_low = v;
               else bank_high = {1'b0, v[0]};
               rom_bank = {bank_high[0], bank_low};
            end
            default: ;
         endcase
      end else if (addr <= 16'h5FFF) begin
         if (kind == cbm_pkg::KIND_MBC1) begin
            bank_high    = v[1:0];
            cur_ram_bank = {2'b00, v[1:0]};
            rom_bank     = {2'b00, bank_high, bank_low[4:0]};
         end else if (kind == cbm_pkg::KIND_MBC3 || kind == cbm_pkg::KIND_MBC5) begin
            cur_ram_bank = v[3:0];
         end
      end else if (addr <= 16'h7FFF) begin
         if (kind == cbm_pkg::KIND_MBC1) bank_mode = v[0];
      end else if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
         if (ram_slot(kind, addr, idx)) save_ram_copy[idx] = v;
      end
   endfunction

   function automatic cbm_pkg::rsp_word_type map_access(input cbm_pkg::req_word_type w);
      cbm_pkg::rsp_word_type  r;
      cbm_pkg::ctrl_kind_type kind;
      int unsigned            lim;
      int unsigned            a;
      int unsigned            t;
      int unsigned            hb;
      int unsigned            bank;
      int unsigned            idx;
      r    = '0;
      kind = decode_kind();
      lim  = (32'(cfg_rom_bytes) < ROM_CAP_BYTES) ? 32'(cfg_rom_bytes) : ROM_CAP_BYTES;
      if (w.func == FUNC_WRITE) begin
         apply_write(kind, w.address, w.write_data);
      end else if (w.address <= 16'h3FFF) begin
         a = 32'(w.address);
         if (kind == cbm_pkg::KIND_MBC1 && bank_mode) begin
            hb = 32'(bank_high);
            t  = hb * 32 * ROM_BANK_BYTES + a;
            if (t < lim) a = t;
         end
         if (a < lim) begin
            r.rom_fetch   = 1'b1;
            r.rom_address = a[22:0];
         end
      end else if (w.address <= 16'h7FFF) begin
         bank = 32'(rom_bank);
         a    = (32'(w.address) - ROM_BANK_BYTES) + bank * ROM_BANK_BYTES;
         if (a < lim) begin
            r.rom_fetch   = 1'b1;
            r.rom_address = a[22:0];
         end
      end else if (w.address >= 16'hA000 && w.address <= 16'hBFFF) begin
         if (ram_slot(kind, w.address, idx)) r.read_data = save_ram_copy[idx];
         else r.read_data = 8'hFF;
      end else begin
         r.read_data = 8'hFF;
      end
      return r;
   endfunction

   function automatic void apply_reg(input logic [1:0] idx, input logic [23:0] v);
      case (idx)
         cbm_pkg::CSR_CART_TYPE: cfg_cart_type = v[7:0];
         cbm_pkg::CSR_RAM_SIZE:  cfg_ram_code  = v[7:0];
         cbm_pkg::CSR_ROM_SIZE:  cfg_rom_bytes = v;
         default: ;
      endcase
   endfunction

   function automatic plan_row_type reg_row(input logic [1:0] idx, input logic [23:0] v);
      plan_row_type p;
      p           = '{default: '0};
      p.is_reg    = 1'b1;
      p.reg_index = idx;
      p.reg_value = v;
      return p;
   endfunction

   function automatic plan_row_type access_row(input logic f, input logic [15:0] a,
                                               input logic [7:0] d);
      plan_row_type p;
      p      = '{default: '0};
      p.word = '{f, a, d};
      return p;
   endfunction

   function automatic plan_row_type checked_row(input logic f, input logic [15:0] a,
                                                input logic [7:0] d, input logic [7:0] rd,
                                                input logic fetch, input logic [22:0] ra);
      plan_row_type p;
      p       = access_row(f, a, d);
      p.typed = 1'b1;
      p.want  = '{rd, fetch, ra};
      return p;
   endfunction

   function automatic logic [7:0] bank_byte();
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      return 8'($urandom_range(0, 7));
   endfunction

   function automatic cbm_pkg::req_word_type random_access();
      cbm_pkg::req_word_type w;
      int unsigned           pick;
      int unsigned           offs;
      pick         = $urandom_range(0, 99);
      offs         = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, 8191);
      w.func       = FUNC_WRITE;
      w.address    = 16'($urandom);
      w.write_data = 8'($urandom);
      if (pick < 8) begin
         w.address    = 16'($urandom_range(16'h0000, 16'h1FFF));
         w.write_data = {4'($urandom), ($urandom_range(0, 2) != 0) ? 4'hA : 4'($urandom)};
      end else if (pick < 18) begin
         w.address    = 16'($urandom_range(16'h2000, 16'h3FFF));
         w.write_data = bank_byte();
      end else if (pick < 26) begin
         w.address    = 16'($urandom_range(16'h4000, 16'h5FFF));
         w.write_data = bank_byte();
      end else if (pick < 30) begin
         w.address = 16'($urandom_range(16'h6000, 16'h7FFF));
      end else if (pick < 50) begin
         w.address = 16'(RAM_BASE + offs);
      end else if (pick < 70) begin
         w.func    = FUNC_READ;
         w.address = 16'(RAM_BASE + offs);
      end else if (pick < 88) begin
         w.func    = FUNC_READ;
         w.address = 16'($urandom_range(16'h0000, 16'h7FFF));
      end else begin
         w.func = 1'($urandom);
      end
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at cycle %0d, %s: got 0x%0h, want 0x%0h",
               cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic set_idling(input int unsigned mode);
      case (mode)
         1:       begin send_idle_pct = 54; rsp_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  rsp_stall_pct = 54; end
         3:       begin send_idle_pct = 20; rsp_stall_pct = 20; end
         default: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      endcase
   endtask

   task automatic send_word(input cbm_pkg::req_word_type w, input logic typed,
                            input cbm_pkg::rsp_word_type want);
      int unsigned seen;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      fixed_answers.push_back('{typed, want});
      seen = bus_words;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(negedge clock); while (bus_words == seen);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] v);
      int unsigned seen;
      seen = reg_writes;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(negedge clock); while (reg_writes == seen);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin : bus_monitor
      cbm_pkg::rsp_word_type model;
      cbm_pkg::rsp_word_type want;
      fixed_answer_type      tag;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            apply_reg(csr_index, csr_wdata);
            reg_writes++;
         end
         if (req_valid && req_ready) begin
            model = map_access(req_word);
            tag   = fixed_answers.pop_front();
            pending_results.push_back(tag.typed ? tag.want : model);
            bus_words++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result word with nothing expected", rsp_word, 32'd0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_word.read_data !== want.read_data)
                  report_mismatch("read_data", 32'(rsp_word.read_data),
                                  32'(want.read_data));
               if (rsp_word.rom_fetch !== want.rom_fetch)
                  report_mismatch("rom_fetch", 32'(rsp_word.rom_fetch),
                                  32'(want.rom_fetch));
               if (rsp_word.rom_address !== want.rom_address)
                  report_mismatch("rom_address", 32'(rsp_word.rom_address),
                                  32'(want.rom_address));
            end
         end
      end
   end

   initial begin
      logic [7:0]  cart;
      logic [7:0]  ram_code;
      logic [23:0] rom_bytes;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_valid = 1'b0;
      csr_index = cbm_pkg::CSR_CART_TYPE;
      csr_wdata = '0;
      cfg_cart_type = '0;
      cfg_ram_code  = '0;
      cfg_rom_bytes = '0;
      bank_low     = 8'd1;
      bank_high    = 2'd0;
      rom_bank     = 9'd1;
      cur_ram_bank = 4'd0;
      ram_on       = 1'b0;
      bank_mode    = 1'b0;
      for (int i = 0; i < cbm_pkg::RAM_BYTES; i++) save_ram_copy[i] = 8'h00;

      directed_plan = '{
         checked_row(FUNC_READ,  16'h0000, 8'h00, 8'h00, 1'b0, 23'h0),
         checked_row(FUNC_READ,  16'hA000, 8'h00, 8'hFF, 1'b0, 23'h0),
         checked_row(FUNC_READ,  16'h8000, 8'h00, 8'hFF, 1'b0, 23'h0),
         checked_row(FUNC_READ,  16'hFFFF, 8'h00, 8'hFF, 1'b0, 23'h0),
         checked_row(FUNC_WRITE, 16'h0000, 8'h0A, 8'h00, 1'b0, 23'h0),
         reg_row(cbm_pkg::CSR_CART_TYPE, 24'h000001),
         reg_row(cbm_pkg::CSR_RAM_SIZE,  24'h000003),
         reg_row(cbm_pkg::CSR_ROM_SIZE,  24'h800000),
         checked_row(FUNC_WRITE, 16'h1FFF, 8'hFA, 8'h00, 1'b0, 23'h0),
         checked_row(FUNC_WRITE, 16'h2000, 8'h00, 8'h00, 1'b0, 23'h0),
         checked_row(FUNC_READ,  16'h4000, 8'h00, 8'h00, 1'b1, 23'h004000),
         access_row(FUNC_WRITE, 16'h4000, 8'h03),
         access_row(FUNC_WRITE, 16'h6000, 8'h01),
         access_row(FUNC_READ,  16'h0000, 8'h00),
         access_row(FUNC_WRITE, 16'hBFFF, 8'hA5),
         access_row(FUNC_READ,  16'hBFFF, 8'h00),
         access_row(FUNC_READ,  16'h7FFF, 8'h00),
         reg_row(cbm_pkg::CSR_ROM_SIZE,  24'h100000),
         access_row(FUNC_READ,  16'h3FFF, 8'h00),
         reg_row(cbm_pkg::CSR_CART_TYPE, 24'h000013),
         reg_row(cbm_pkg::CSR_ROM_SIZE,  24'h00014F),
         checked_row(FUNC_READ,  16'hA000, 8'h00, 8'hFF, 1'b0, 23'h0),
         access_row(FUNC_READ,  16'h4000, 8'h00),
         reg_row(cbm_pkg::CSR_ROM_SIZE,  24'h008000),
         access_row(FUNC_WRITE, 16'h2000, 8'h80),
         access_row(FUNC_READ,  16'h7FFF, 8'h00),
         reg_row(cbm_pkg::CSR_CART_TYPE, 24'h00001E),
         reg_row(cbm_pkg::CSR_RAM_SIZE,  24'h000004),
         reg_row(cbm_pkg::CSR_ROM_SIZE,  24'h800000),
         access_row(FUNC_WRITE, 16'h2000, 8'h00),
         access_row(FUNC_WRITE, 16'h3000, 8'h01),
         access_row(FUNC_WRITE, 16'h4000, 8'h0F),
         access_row(FUNC_WRITE, 16'hA000, 8'h5A),
         access_row(FUNC_READ,  16'hA000, 8'h00),
         access_row(FUNC_READ,  16'h7FFF, 8'h00),
         access_row(FUNC_WRITE, 16'h0000, 8'h00),
         checked_row(FUNC_READ,  16'hA000, 8'h00, 8'hFF, 1'b0, 23'h0),
         reg_row(cbm_pkg::CSR_CART_TYPE, 24'h0000FF),
         reg_row(cbm_pkg::CSR_RAM_SIZE,  24'h0000FF),
         reg_row(CSR_UNUSED,             24'hFFFFFF),
         access_row(FUNC_WRITE, 16'h2000, 8'hFF),
         access_row(FUNC_READ,  16'h4000, 8'h00)
      };

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      set_idling(0);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_reg) begin
            drain_results();
            write_reg(directed_plan[i].reg_index, directed_plan[i].reg_value);
         end else begin
            send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want);
         end
      end

      for (int s = 0; s < SEGMENTS; s++) begin
         set_idling((s + s / 4) % 4);
         drain_results();
         case (s % 4)
            0:       cart = 8'($urandom_range(8'h01, 8'h03));
            1:       cart = 8'($urandom_range(8'h0F, 8'h13));
            2:       cart = 8'($urandom_range(8'h19, 8'h1E));
            default: cart = 8'($urandom);
         endcase
         ram_code = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 5)) : 8'($urandom);
         case ($urandom_range(0, 6))
            0:       rom_bytes = 24'($urandom_range(0, cbm_pkg::HEADER_END));
            1:       rom_bytes = 24'h008000;
            2:       rom_bytes = 24'h080000;
            3:       rom_bytes = 24'h200000;
            6:       rom_bytes = 24'($urandom_range(cbm_pkg::HEADER_END, ROM_CAP_BYTES));
            default: rom_bytes = 24'h800000;
         endcase
         write_reg(cbm_pkg::CSR_CART_TYPE, {16'h0, cart});
         write_reg(cbm_pkg::CSR_RAM_SIZE, {16'h0, ram_code});
         write_reg(cbm_pkg::CSR_ROM_SIZE, rom_bytes);
         for (int n = 0; n < SEGMENT_WORDS; n++) begin
            // hold off until the mapper has answered everything in flight
            if (n == SEGMENT_WORDS / 2) drain_results();
            send_word(random_access(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(negedge clock);
      if (pending_results.size() != 0)
         report_mismatch("result words never delivered", 32'd0,
                         32'(pending_results.size()));
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
